/* src/wfr_pkg.sv */
// Package for the Wiegand / clock-data frame receiver.
// Holds the operation and register codes, the payload structs and default sizes.
// No dependencies; every other file of the block imports it.
package wfr_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MODE    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Default buffer size in bits.
  localparam int MAX_BITS_DEFAULT = 128;

  // Bytes that the 4-bit byte index can reach.
  localparam int READ_BYTES = 16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  typedef struct packed {
    logic [1:0] operation;
    logic       data_line;
    logic [3:0] byte_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [7:0]  bit_count;
    logic        frame_done;
    logic [31:0] frames_done_count;
    logic [31:0] overrun_count;
    logic        mode_select;
  } result_t;

  // Frame status after one step, everything of a result except the read byte.
  typedef struct packed {
    logic [7:0]  bit_count;
    logic        frame_done;
    logic [31:0] frames_done_count;
    logic [31:0] overrun_count;
    logic        mode_select;
  } status_t;

endpackage

/* src/wfr_bit_store.sv */
// Bit buffer of the frame receiver: one bit written per clock edge while wr_en is high, one byte read.
// Bits at or beyond the fill count read as zero, so a new frame needs no clearing.
// Depends on wfr_pkg.
module wfr_bit_store #(
  parameter int MAX_BITS = wfr_pkg::MAX_BITS_DEFAULT,
  parameter int TW       = $clog2(MAX_BITS + 1)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [TW-1:0] wr_pos,
  input  logic          wr_bit,
  input  logic [3:0]    rd_idx,
  input  logic [TW-1:0] fill,
  output logic [7:0]    rd_byte
);
  import wfr_pkg::*;

  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  // Only bytes that the read index can reach are kept.
  localparam int NB  = (STORE_BYTES < READ_BYTES) ? STORE_BYTES : READ_BYTES;
  localparam int NBW = (NB > 1) ? $clog2(NB) : 1;

  logic [7:0]  mem [NB];
  logic [31:0] wr_byte;
  logic [31:0] rd_byte_idx;
  logic [31:0] base;
  logic [31:0] fill32;
  logic [7:0]  raw;
  logic [7:0]  mask;

  assign wr_byte = 32'(wr_pos) >> 3;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_byte < 32'(NB))) begin
      mem[wr_byte[NBW-1:0]][~wr_pos[2:0]] <= wr_bit;
    end
  end

  assign rd_byte_idx = 32'(rd_idx);
  assign base        = rd_byte_idx << 3;
  assign fill32      = 32'(fill);

  always_comb begin
    raw = 8'h00;
    if (rd_byte_idx < 32'(NB)) begin
      raw = mem[rd_byte_idx[NBW-1:0]];
    end
    for (int j = 0; j < 8; j++) begin
      mask[7-j] = (base + 32'(j)) < fill32;
    end
  end

  assign rd_byte = raw & mask;

endmodule

/* src/wfr_frame_ctrl.sv */
// Frame control of the receiver: bit count, done flag, idle timer, tallies and
// the configuration registers. Depends on wfr_pkg.
module wfr_frame_ctrl #(
  parameter int MAX_BITS = wfr_pkg::MAX_BITS_DEFAULT,
  parameter int TW       = $clog2(MAX_BITS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               exec,
  input  logic [1:0]                         op,
  input  logic                               data_line,
  input  logic                               cfg_write_en,
  input  logic [wfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               wr_en,
  output logic [TW-1:0]                      wr_pos,
  output logic                               wr_bit,
  output logic [TW-1:0]                      fill,
  output wfr_pkg::status_t                   status_next
);
  import wfr_pkg::*;

  logic [TW-1:0] total, total_next, total_eff;
  logic          done, done_next;
  logic [15:0]   timer, timer_next;
  logic [31:0]   tally_done, tally_done_next;
  logic [31:0]   tally_over, tally_over_next;
  logic          enable, enable_next;
  logic          mode, mode_next;
  logic [15:0]   timeout, timeout_next;
  logic [31:0]   total32;

  always_comb begin
    total_next      = total;
    done_next       = done;
    timer_next      = timer;
    tally_done_next = tally_done;
    tally_over_next = tally_over;
    enable_next     = enable;
    mode_next       = mode;
    timeout_next    = timeout;
    total_eff       = done ? '0 : total;
    wr_en           = 1'b0;
    wr_pos          = total_eff;
    wr_bit          = ~data_line;

    if (exec) begin
      case (op)
        OP_EDGE: begin
          if (enable) begin
            // A finished frame is dropped before the new bit goes in.
            if (done) begin
              total_next = '0;
              done_next  = 1'b0;
            end
            if (32'(total_eff) < 32'(MAX_BITS)) begin
              wr_en      = 1'b1;
              total_next = total_eff + TW'(1);
              timer_next = (timeout == 16'd0) ? 16'd1 : timeout;
            end
          end
        end
        OP_TICK: begin
          if (timer != 16'd0) begin
            timer_next = timer - 16'd1;
            if ((timer == 16'd1) && !done) begin
              done_next = 1'b1;
              if (32'(total) >= 32'(MAX_BITS)) begin
                tally_over_next = tally_over + 32'd1;
              end else begin
                tally_done_next = tally_done + 32'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cfg_write_en) begin
      case (cfg_index)
        REG_ENABLE: begin
          if (cfg_data[0] && !enable) begin
            total_next = '0;
            done_next  = 1'b0;
          end
          enable_next = cfg_data[0];
        end
        REG_MODE: begin
          if (cfg_data[0] != mode) begin
            total_next = '0;
            done_next  = 1'b0;
          end
          mode_next = cfg_data[0];
        end
        REG_TIMEOUT: begin
          timeout_next = cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      done       <= 1'b0;
      timer      <= 16'd0;
      tally_done <= 32'd0;
      tally_over <= 32'd0;
      enable     <= 1'b0;
      mode       <= 1'b1;
      timeout    <= TIMEOUT_RESET;
    end else begin
      total      <= total_next;
      done       <= done_next;
      timer      <= timer_next;
      tally_done <= tally_done_next;
      tally_over <= tally_over_next;
      enable     <= enable_next;
      mode       <= mode_next;
      timeout    <= timeout_next;
    end
  end

  assign fill    = total;
  assign total32 = 32'(total_next);

  always_comb begin
    status_next.bit_count         = (total32 > 32'd255) ? 8'hFF : total32[7:0];
    status_next.frame_done        = done_next;
    status_next.frames_done_count = tally_done_next;
    status_next.overrun_count     = tally_over_next;
    status_next.mode_select       = mode_next;
  end

endmodule

/* src/wiegand_frame_receiver.sv */
// A transferred item sits in the input register, and the step logic loads the result register
// from it as the item advances. Throughput is one item per cycle while results are taken,
// every operation being one step. While a result waits untaken, the input register keeps its
// item, so one more item transfers and then input stalls.
// Reset (rst, synchronous, active high) empties both registers, clears counts, tallies and
// timer, disables reception, selects Wiegand mode and sets the timeout to 50 ticks.
module wiegand_frame_receiver #(
  parameter int MAX_BITS = wfr_pkg::MAX_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  wfr_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output wfr_pkg::result_t                result,
  input  logic                            cfg_write_en,
  input  logic [wfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wfr_pkg::*;

  // Width of the bit counter, able to hold MAX_BITS itself.
  localparam int TW = $clog2(MAX_BITS + 1);

  // Input register: holds the item taken in the previous transfer.
  item_t   item_q;
  logic    item_full;
  // The item in the input register is executed in the cycle it moves on.
  logic    advance;

  status_t       status_next;
  logic          wr_en;
  logic [TW-1:0] wr_pos;
  logic          wr_bit;
  logic [TW-1:0] fill;
  logic [7:0]    rd_byte;
  logic [7:0]    read_byte;

  // The input register moves on whenever the result register is empty or is being
  // emptied in the same cycle; a result that is waiting untaken holds it back.
  assign advance    = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Frame state: all updates for an edge or a tick happen as the item advances.
  wfr_frame_ctrl #(
    .MAX_BITS (MAX_BITS),
    .TW       (TW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .exec         (advance),
    .op           (item_q.operation),
    .data_line    (item_q.data_line),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wr_en        (wr_en),
    .wr_pos       (wr_pos),
    .wr_bit       (wr_bit),
    .fill         (fill),
    .status_next  (status_next)
  );

  // The buffer is read with the count as it stands; a read never changes the frame.
  wfr_bit_store #(
    .MAX_BITS (MAX_BITS),
    .TW       (TW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_pos  (wr_pos),
    .wr_bit  (wr_bit),
    .rd_idx  (item_q.byte_index),
    .fill    (fill),
    .rd_byte (rd_byte)
  );

  // The read byte is only meaningful for a read; every other operation shows zero.
  assign read_byte = (item_q.operation == OP_READ) ? rd_byte : 8'h00;

  // Result register: loaded with the state after the step.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.read_byte         <= read_byte;
      result.bit_count         <= status_next.bit_count;
      result.frame_done        <= status_next.frame_done;
      result.frames_done_count <= status_next.frames_done_count;
      result.overrun_count     <= status_next.overrun_count;
      result.mode_select       <= status_next.mode_select;
    end
  end

endmodule

/* src/wfr_checker.sv */
// Port-level checks for the frame receiver, attached to the top level by bind.
// Depends on wfr_pkg and on the ports of wiegand_frame_receiver.
module wfr_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input wfr_pkg::result_t result
);
  import wfr_pkg::*;

  logic        seen;
  logic [31:0] last_done;
  logic [31:0] last_over;
  logic        last_fd;
  logic        take;

  assign take = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (take) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last_done <= result.frames_done_count;
      last_over <= result.overrun_count;
      last_fd   <= result.frame_done;
    end
  end

  // A held result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // No result is on show straight after reset.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // One step ends at most one frame, so the tallies together grow by at most one.
  a_tally_step: assert property (@(posedge clk) disable iff (rst)
    take && seen |->
      ((result.frames_done_count == last_done) && (result.overrun_count == last_over)) ||
      ((result.frames_done_count == last_done + 32'd1) && (result.overrun_count == last_over)) ||
      ((result.frames_done_count == last_done) && (result.overrun_count == last_over + 32'd1)))
    else $error("tallies moved by more than one frame");

  // A frame becomes done only by the expiry that also counts it.
  a_done_counted: assert property (@(posedge clk) disable iff (rst)
    take && seen && !last_fd && result.frame_done |->
      (result.frames_done_count != last_done) || (result.overrun_count != last_over))
    else $error("frame ended without being counted");

endmodule

bind wiegand_frame_receiver wfr_checker u_wfr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* verif/tb_wiegand_frame_receiver.sv */
// Self-checking testbench for the Wiegand / clock-data frame receiver.
// Needs wfr_pkg and wiegand_frame_receiver from src, with wfr_frame_ctrl and wfr_bit_store below it.
`timescale 1ns / 1ps

module tb_wiegand_frame_receiver;
  import wfr_pkg::*;

  // The block is built with its default buffer size, so the scoreboard uses the same.
  localparam int FRAME_MAX   = MAX_BITS_DEFAULT;
  localparam int STORE_BYTES = (FRAME_MAX + 7) / 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_BUDGET = 1150;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  wiegand_frame_receiver uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Scoreboard copy of the receiver state. Bit 0 of frame_bits is the first bit of
  // the frame, which the block returns in the MSB of byte 0.
  logic [FRAME_MAX-1:0] frame_bits;
  int unsigned          frame_len;
  logic                 frame_ended;
  int unsigned          idle_left;
  logic [31:0]          good_frames;
  logic [31:0]          overrun_frames;
  logic                 rx_enable;
  logic                 rx_mode;
  logic [15:0]          idle_timeout;

  item_t   pending_items[$];
  result_t expected_results[$];
  result_t want;

  int items_offered;
  int items_taken;
  int results_taken;
  int mismatches;
  int input_stalls;
  int cycle_count;
  int budget_items;
  int phase_count;
  bit count_toward_budget;

  // Sender burst shaping and receiver stall shaping.
  int burst_left;
  int gap_left;
  int ready_style;
  int style_left;
  int holdoff_left;
  bit holdoff_done;

  // A new frame forgets its bits, its length and its done flag; the counters and the
  // idle timer carry on.
  function automatic void clear_frame();
    frame_bits  = '0;
    frame_len   = 0;
    frame_ended = 1'b0;
  endfunction

  // Mirrors a register write. Enabling reception or switching mode starts a fresh frame.
  function automatic void apply_reg(logic [1:0] idx, logic [15:0] value);
    case (idx)
      REG_ENABLE: begin
        if (value[0] && !rx_enable) clear_frame();
        rx_enable = value[0];
      end
      REG_MODE: begin
        if (value[0] != rx_mode) clear_frame();
        rx_mode = value[0];
      end
      REG_TIMEOUT: idle_timeout = value;
      default: ;
    endcase
  endfunction

  // Works out the result that one transferred item causes and queues it.
  function automatic void predict_result(item_t it);
    logic [7:0] rd;
    result_t    r;
    int         k;
    rd = '0;
    case (it.operation)
      OP_EDGE: begin
        if (rx_enable) begin
          if (frame_ended) clear_frame();
          // A full buffer swallows the edge and leaves the timer running down.
          if (frame_len < FRAME_MAX) begin
            frame_bits[frame_len] = ~it.data_line;
            frame_len++;
            idle_left = (idle_timeout == 16'd0) ? 1 : idle_timeout;
          end
        end
      end
      OP_TICK: begin
        if (idle_left != 0) begin
          idle_left--;
          if (idle_left == 0 && !frame_ended) begin
            frame_ended = 1'b1;
            if (frame_len >= FRAME_MAX) overrun_frames++;
            else good_frames++;
          end
        end
      end
      OP_READ: begin
        if (int'(it.byte_index) < STORE_BYTES) begin
          for (k = 0; k < 8; k++) rd[7-k] = frame_bits[int'(it.byte_index) * 8 + k];
        end
      end
      default: ;
    endcase
    r.read_byte         = rd;
    r.bit_count         = (frame_len > 255) ? 8'd255 : frame_len[7:0];
    r.frame_done        = frame_ended;
    r.frames_done_count = good_frames;
    r.overrun_count     = overrun_frames;
    r.mode_select       = rx_mode;
    expected_results.push_back(r);
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  function automatic void push_item(logic [1:0] op, logic level, logic [3:0] idx);
    item_t it;
    it.operation  = op;
    it.data_line  = level;
    it.byte_index = idx;
    pending_items.push_back(it);
    if (count_toward_budget) budget_items++;
  endfunction

  // Register writes only ever happen while the block is idle, so the scoreboard can
  // take the new setting straight away.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    apply_reg(idx, value);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Waits until every queued item has been transferred and every result checked,
  // then gives the two pipeline registers time to drain.
  task automatic wait_idle();
    while (pending_items.size() != 0 || items_taken != items_offered ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Queues one reader frame: the edges, a little noise in between, the idle ticks that
  // end it, and a readout of the bytes it filled.
  task automatic queue_frame(input int nbits);
    int b;
    int ticks;
    int nbytes;
    for (b = 0; b < nbits; b++) begin
      push_item(OP_EDGE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      case ($urandom_range(0, 29))
        0: push_item(OP_READ, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        1: begin
          // A stray tick mid-frame only stays harmless when the timeout exceeds one.
          if (idle_timeout > 16'd1)
            push_item(OP_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
        2: push_item(OP_UNUSED, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        default: ;
      endcase
    end
    ticks = (idle_timeout == 16'd0) ? 1 : int'(idle_timeout);
    ticks += $urandom_range(0, 2);
    repeat (ticks) push_item(OP_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    nbytes = (nbits + 7) / 8;
    if (nbytes > 16) nbytes = 16;
    for (b = 0; b < nbytes; b++) push_item(OP_READ, 1'($urandom_range(0, 1)), 4'(b));
    push_item(OP_READ, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  // Driver: presents queued items in bursts of random length separated by random gaps.
  // An offered item is held, payload and all, until the monitor has counted its transfer.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items_taken == items_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        items_offered++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                   : $urandom_range(0, 2);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall styles every so often. Once, when enough traffic is
  // waiting, it refuses results for a long stretch so that the block backs up and stops
  // accepting input.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (!holdoff_done && results_taken >= 300 && pending_items.size() > 8) begin
        holdoff_done = 1'b1;
        holdoff_left = 250;
      end
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 3);
        style_left  = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_ready <= 1'b0;
      end else begin
        case (ready_style)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= (cycle_count % 5) != 0;
        endcase
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation and feeds each
  // item transfer to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_byte", want.read_byte, result.read_byte);
          check_field("bit_count", want.bit_count, result.bit_count);
          check_field("frame_done", want.frame_done, result.frame_done);
          check_field("frames_done_count", want.frames_done_count,
                      result.frames_done_count);
          check_field("overrun_count", want.overrun_count, result.overrun_count);
          check_field("mode_select", want.mode_select, result.mode_select);
        end
      end
      if (item_valid && item_ready) begin
        items_taken++;
        predict_result(item);
      end
      if (item_valid && !item_ready) input_stalls++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_results.size());
      $display("wiegand_frame_receiver regression: fail");
      $finish;
    end
  end

  initial begin
    int nframes;
    int f;
    int len;
    logic en;
    logic md;
    logic [15:0] tmo;

    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;

    items_offered = 0;
    items_taken   = 0;
    results_taken = 0;
    mismatches    = 0;
    input_stalls  = 0;
    cycle_count   = 0;
    budget_items  = 0;
    phase_count   = 0;
    burst_left    = 1;
    gap_left      = 0;
    ready_style   = 0;
    style_left    = 0;
    holdoff_left  = 0;
    holdoff_done  = 1'b0;
    count_toward_budget = 1'b0;

    // State after reset: reception off, Wiegand mode, a 50 tick timeout.
    clear_frame();
    idle_left      = 0;
    good_frames    = '0;
    overrun_frames = '0;
    rx_enable      = 1'b0;
    rx_mode        = 1'b1;
    idle_timeout   = TIMEOUT_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Straight after reset: an edge is ignored while reception is off, a tick does
    // nothing with the timer unarmed, the empty buffer reads as zero and the unused
    // operation code is a no-op.
    push_item(OP_EDGE, 1'b0, 4'd0);
    push_item(OP_TICK, 1'b0, 4'd0);
    push_item(OP_READ, 1'b0, 4'd0);
    push_item(OP_READ, 1'b1, 4'd15);
    push_item(OP_UNUSED, 1'b1, 4'd15);
    wait_idle();

    // A zero timeout behaves as one tick: two bits, expiry on the first tick, a second
    // tick with nothing armed, then an edge on the finished frame that starts a new one.
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_TIMEOUT, 16'd0);
    push_item(OP_EDGE, 1'b0, 4'd15);
    push_item(OP_EDGE, 1'b1, 4'd0);
    push_item(OP_READ, 1'b0, 4'd0);
    push_item(OP_READ, 1'b0, 4'd15);
    push_item(OP_TICK, 1'b1, 4'd0);
    push_item(OP_TICK, 1'b0, 4'd0);
    push_item(OP_EDGE, 1'b0, 4'd0);
    push_item(OP_READ, 1'b1, 4'd0);
    push_item(OP_UNUSED, 1'b0, 4'd0);
    wait_idle();

    // Longest timeout and a mode change, which clears the frame but keeps the timer.
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_MODE, 16'd0);
    push_item(OP_EDGE, 1'b1, 4'd0);
    push_item(OP_EDGE, 1'b0, 4'd0);
    push_item(OP_TICK, 1'b0, 4'd0);
    push_item(OP_READ, 1'b0, 4'd0);
    wait_idle();

    // Disabling drops edges; enabling again clears the frame.
    write_reg(REG_ENABLE, 16'd0);
    push_item(OP_EDGE, 1'b0, 4'd0);
    push_item(OP_READ, 1'b0, 4'd0);
    wait_idle();
    write_reg(REG_ENABLE, 16'd1);
    push_item(OP_READ, 1'b0, 4'd0);
    wait_idle();
    phase_count = 5;

    // Random phases: each picks a setting, then streams whole frames of random length.
    // Now and then a frame runs to the full buffer or beyond, ending as an overrun.
    while (budget_items < ITEM_BUDGET) begin
      en = ($urandom_range(0, 9) != 0);
      md = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: tmo = 16'd0;
        1: tmo = 16'd1;
        default: tmo = 16'($urandom_range(2, 6));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_ENABLE, 16'd0);
      write_reg(REG_ENABLE, {15'd0, en});
      write_reg(REG_MODE, {15'd0, md});
      write_reg(REG_TIMEOUT, tmo);
      count_toward_budget = 1'b1;
      nframes = $urandom_range(2, 5);
      for (f = 0; f < nframes && budget_items < ITEM_BUDGET; f++) begin
        case ($urandom_range(0, 11))
          0: len = FRAME_MAX;
          1: len = $urandom_range(FRAME_MAX - 8, FRAME_MAX + 8);
          2: len = 26;
          3: len = 34;
          default: len = $urandom_range(1, 40);
        endcase
        queue_frame(len);
      end
      wait_idle();
      phase_count++;
    end
    count_toward_budget = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end

    $display("Checked %0d results from %0d items over %0d settings: %0d frames done, %0d overruns.",
             results_taken, items_taken, phase_count, good_frames, overrun_frames);
    $display("Input was held off for %0d cycles; %0d mismatches found.",
             input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("wiegand_frame_receiver regression: pass");
    end else begin
      $display("wiegand_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/wfr_pkg.sv
src/wfr_bit_store.sv
src/wfr_frame_ctrl.sv
src/wiegand_frame_receiver.sv
src/wfr_checker.sv
verif/tb_wiegand_frame_receiver.sv
